// File: rtl/core/pswd_pkg.sv
`default_nettype none

package pswd_pkg;

  localparam int TIME_W  = 63;
  localparam int LIMIT_W = 8;
  localparam int SEC_W   = 12;
  localparam int NS_W    = 42;  // 3600 s in nanoseconds fits in 42 bits
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [NS_W-1:0] NS_PER_SEC = NS_W'(64'd1_000_000_000);

  localparam logic [LIMIT_W-1:0] IDLE_LIMIT_RST = LIMIT_W'(3);
  localparam logic [SEC_W-1:0]   COOLDOWN_RST   = SEC_W'(30);
  localparam logic [SEC_W-1:0]   FRESH_RST      = SEC_W'(10);

  typedef enum logic [1:0] {
    OP_IMAGE  = 2'd0,
    OP_INFER  = 2'd1,
    OP_DETECT = 2'd2,
    OP_CHECK  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IDLE_LIMIT = 2'd0,
    CFG_COOLDOWN   = 2'd1,
    CFG_FRESH      = 2'd2
  } cfg_idx_t;

  // Per-stage update request for one event.
  typedef struct packed {
    logic rec_in;
    logic rec_out;
    logic check;
  } stage_cmd_t;

  // Thresholds shared by both stages.
  typedef struct packed {
    logic [LIMIT_W-1:0] idle_limit;
    logic [NS_W-1:0]    cool_ns;
    logic [NS_W-1:0]    fresh_ns;
  } stage_cfg_t;

endpackage

`default_nettype wire

// File: rtl/core/pswd_if.sv
`default_nettype none

interface pswd_evt_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    op;
  logic [pswd_pkg::TIME_W-1:0]   time_ns;

  modport source (output valid, output op, output time_ns, input ready);
  modport sink   (input valid, input op, input time_ns, output ready);
endinterface

interface pswd_res_if;
  logic valid;
  logic ready;
  logic reset_detector;
  logic reset_visualizer;

  modport source (output valid, output reset_detector, output reset_visualizer, input ready);
  modport sink   (input valid, input reset_detector, input reset_visualizer, output ready);
endinterface

`default_nettype wire

// File: rtl/core/pswd_stage.sv
`default_nettype none

module pswd_stage (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire pswd_pkg::stage_cmd_t        cmd,
  input  wire pswd_pkg::stage_cfg_t        cfg,
  input  wire logic [pswd_pkg::TIME_W-1:0] now,
  output logic                             fire
);
  import pswd_pkg::*;

  logic [TIME_W-1:0]  in_time;
  logic [TIME_W-1:0]  out_time;
  logic [TIME_W-1:0]  rst_time;
  logic [LIMIT_W-1:0] count;

  logic signed [TIME_W:0] diff_in;
  logic signed [TIME_W:0] diff_rst;
  logic                   never_in;
  logic                   stale;
  logic                   out_newer;
  logic                   cooling;
  logic                   counted;
  logic [LIMIT_W:0]       count_inc;

  // Stored times are 63 bits, so a 64-bit signed difference never overflows.
  assign diff_in  = $signed({1'b0, now}) - $signed({1'b0, in_time});
  assign diff_rst = $signed({1'b0, now}) - $signed({1'b0, rst_time});

  assign never_in  = (in_time == '0);
  assign stale     = diff_in > $signed({{(TIME_W + 1 - NS_W){1'b0}}, cfg.fresh_ns});
  assign out_newer = (out_time != '0) && (out_time >= in_time);
  assign cooling   = (rst_time != '0) &&
                     (diff_rst < $signed({{(TIME_W + 1 - NS_W){1'b0}}, cfg.cool_ns}));

  assign counted   = cmd.check && !never_in && !stale && !out_newer && !cooling;
  assign count_inc = {1'b0, count} + (LIMIT_W + 1)'(1);
  assign fire      = counted && (count_inc >= {1'b0, cfg.idle_limit});

  always_ff @(posedge clk) begin
    if (rst) begin
      in_time  <= '0;
      out_time <= '0;
      rst_time <= '0;
      count    <= '0;
    end else begin
      if (cmd.rec_in) begin
        in_time <= now;
      end
      if (cmd.rec_out) begin
        out_time <= now;
        count    <= '0;
      end else if (counted) begin
        count <= fire ? '0 : count_inc[LIMIT_W-1:0];
      end
      if (fire) begin
        rst_time <= now;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/pipeline_stall_watchdog.sv
`default_nettype none

// Channel  Role    Payload                             Width
// evt      sink    op, time_ns                         2, 63
// res      source  reset_detector, reset_visualizer    1, 1
// cfg_*    write   cfg_index, cfg_data                 2, 12
//
// Each request is captured in an input register and evaluated from there once the
// result register can advance; the result register then loads both stage flags and
// offers the result. One request per cycle is taken while the result side is not stalled.
// Both stage checks run in parallel from the input register into the result register.
// A stalled result register holds the input register; the input side stays open
// while the input register is empty or moving. rst clears all times and counters
// and restores the register defaults.

module pipeline_stall_watchdog (
  input  wire logic                             clk,
  input  wire logic                             rst,
  pswd_evt_if.sink                              evt,
  pswd_res_if.source                            res,
  input  wire logic                             cfg_we,
  input  wire logic [pswd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pswd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import pswd_pkg::*;

  logic [LIMIT_W-1:0] idle_limit;
  logic [NS_W-1:0]    cool_ns;
  logic [NS_W-1:0]    fresh_ns;
  stage_cfg_t         scfg;

  logic              evt_vld;
  op_t               op_r;
  logic [TIME_W-1:0] time_r;
  logic              advance;
  logic              go;

  stage_cmd_t cmd_det;
  stage_cmd_t cmd_vis;
  logic       fire_det;
  logic       fire_vis;
  logic       res_vld;
  logic       res_det;
  logic       res_vis;

  function automatic logic [NS_W-1:0] sec_to_ns(logic [SEC_W-1:0] s);
    return NS_W'({{(NS_W - SEC_W){1'b0}}, s} * NS_PER_SEC);
  endfunction

  // Thresholds are kept in nanoseconds; the multiply sits on the write path.
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_limit <= IDLE_LIMIT_RST;
      cool_ns    <= sec_to_ns(COOLDOWN_RST);
      fresh_ns   <= sec_to_ns(FRESH_RST);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDLE_LIMIT: idle_limit <= cfg_data[LIMIT_W-1:0];
        CFG_COOLDOWN:   cool_ns    <= sec_to_ns(cfg_data[SEC_W-1:0]);
        CFG_FRESH:      fresh_ns   <= sec_to_ns(cfg_data[SEC_W-1:0]);
        default: ;
      endcase
    end
  end

  assign scfg = {idle_limit, cool_ns, fresh_ns};

  assign advance   = !res_vld || res.ready;
  assign go        = evt_vld && advance;
  assign evt.ready = !evt_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      evt_vld <= 1'b0;
    end else if (evt.valid && evt.ready) begin
      evt_vld <= 1'b1;
    end else if (advance) begin
      evt_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.valid && evt.ready) begin
      op_r   <= op_t'(evt.op);
      time_r <= evt.time_ns;
    end
  end

  always_comb begin
    cmd_det = '0;
    cmd_vis = '0;
    if (go) begin
      unique case (op_r)
        OP_IMAGE: cmd_det.rec_in = 1'b1;
        OP_INFER: begin
          cmd_det.rec_out = 1'b1;
          cmd_vis.rec_in  = 1'b1;
        end
        OP_DETECT: cmd_vis.rec_out = 1'b1;
        OP_CHECK: begin
          cmd_det.check = 1'b1;
          cmd_vis.check = 1'b1;
        end
        default: ;
      endcase
    end
  end

  pswd_stage u_det (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd_det),
    .cfg  (scfg),
    .now  (time_r),
    .fire (fire_det)
  );

  pswd_stage u_vis (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd_vis),
    .cfg  (scfg),
    .now  (time_r),
    .fire (fire_vis)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (advance) begin
      res_vld <= evt_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      res_det <= fire_det;
      res_vis <= fire_vis;
    end
  end

  assign res.valid            = res_vld;
  assign res.reset_detector   = res_det;
  assign res.reset_visualizer = res_vis;

  // A result only appears for a request held in the input register.
  a_res_from_req: assert property (@(posedge clk) disable iff (rst)
    $rose(res_vld) |-> $past(evt_vld))
    else $error("result raised without a pending request");

  // Only a check tick may request a stage reset.
  a_flags_on_check: assert property (@(posedge clk) disable iff (rst)
    go && (op_r != OP_CHECK) |=> !res_det && !res_vis)
    else $error("reset flag raised on a non-check event");

  // A blocked input register keeps its request.
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    evt_vld && !advance |=> evt_vld && $stable(time_r) && $stable(op_r))
    else $error("pending request lost during stall");

endmodule

`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import pswd_pkg::*;

  localparam longint unsigned NS_S = 64'd1_000_000_000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam bit [TIME_W-1:0] MAX_T = '1;
  localparam int QUIET_LIMIT = 3000;
  localparam int LONG_HOLD = 300;

  typedef struct {
    op_t              op;
    bit [TIME_W-1:0]  t_ns;
  } evt_req_t;

  typedef struct {
    bit det;
    bit vis;
  } stall_flags_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pswd_evt_if evt ();
  pswd_res_if res ();

  pipeline_stall_watchdog dut (
    .clk       (clk),
    .rst       (rst),
    .evt       (evt),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Stall-watch state and thresholds, mirrored on the testbench side.
  bit [TIME_W-1:0]  in_ns [2];
  bit [TIME_W-1:0]  out_ns [2];
  bit [TIME_W-1:0]  rst_ns [2];
  bit [LIMIT_W-1:0] idle_cnt [2];
  bit [LIMIT_W-1:0] lim_r;
  bit [SEC_W-1:0]   cool_s;
  bit [SEC_W-1:0]   fresh_s;

  evt_req_t     req_q [$];
  stall_flags_t flags_q [$];

  int err_cnt;
  int send_idle_pct;
  int recv_idle_pct;
  int rx_count;
  int hold_left;
  bit hold_done;
  int quiet_cycles;
  bit [TIME_W-1:0] now_t;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic flag_error(string what);
    $display("ERROR at %0t: %s", $time, what);
    err_cnt++;
  endtask

  function automatic bit stage_trips(int s, bit [TIME_W-1:0] t);
    longint d_in;
    longint d_rst;
    longint a;
    longint b;
    int cnt;
    a = {1'b0, t};
    b = {1'b0, in_ns[s]};
    d_in = a - b;
    b = {1'b0, rst_ns[s]};
    d_rst = a - b;
    if (in_ns[s] == 0) return 1'b0;
    if (d_in > longint'(fresh_s) * longint'(NS_S)) return 1'b0;
    if (out_ns[s] != 0 && out_ns[s] >= in_ns[s]) return 1'b0;
    if (rst_ns[s] != 0 && d_rst < longint'(cool_s) * longint'(NS_S)) return 1'b0;
    cnt = idle_cnt[s] + 1;
    if (cnt < lim_r) begin
      idle_cnt[s] = cnt[LIMIT_W-1:0];
      return 1'b0;
    end
    idle_cnt[s] = '0;
    rst_ns[s] = t;
    return 1'b1;
  endfunction

  function automatic stall_flags_t watch_step(op_t op, bit [TIME_W-1:0] t);
    stall_flags_t f;
    f.det = 1'b0;
    f.vis = 1'b0;
    case (op)
      OP_IMAGE: in_ns[0] = t;
      OP_INFER: begin
        out_ns[0] = t;
        idle_cnt[0] = '0;
        in_ns[1] = t;
      end
      OP_DETECT: begin
        out_ns[1] = t;
        idle_cnt[1] = '0;
      end
      default: begin
        // The detector is checked before the visualizer, at the same time value.
        f.det = stage_trips(0, t);
        f.vis = stage_trips(1, t);
      end
    endcase
    return f;
  endfunction

  function automatic void push_req(op_t op, bit [TIME_W-1:0] t);
    evt_req_t r;
    r.op = op;
    r.t_ns = t;
    req_q.push_back(r);
  endfunction

  function automatic bit [TIME_W-1:0] rand_ns(longint unsigned maxv);
    longint unsigned r;
    r = {$urandom, $urandom};
    return TIME_W'(r % (maxv + 1));
  endfunction

  function automatic bit [TIME_W-1:0] sec(int s);
    return TIME_W'(64'(s) * NS_S);
  endfunction

  // Request driver.
  always @(posedge clk) begin : drv
    evt_req_t r;
    if (rst) begin
      evt.valid <= 1'b0;
    end else begin
      if (evt.valid && evt.ready)
        flags_q.push_back(watch_step(op_t'(evt.op), evt.time_ns));
      if (!evt.valid || evt.ready) begin
        if (req_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          r = req_q.pop_front();
          evt.valid <= 1'b1;
          evt.op <= r.op;
          evt.time_ns <= r.t_ns;
        end else begin
          evt.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor; it also holds off once for a long stretch to back the block up.
  always @(posedge clk) begin : mon
    stall_flags_t e;
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        rx_count++;
        if (flags_q.size() == 0) begin
          flag_error("result arrived with no request outstanding");
        end else begin
          e = flags_q.pop_front();
          if (res.reset_detector !== e.det)
            flag_error($sformatf("reset_detector %b, expected %b", res.reset_detector, e.det));
          if (res.reset_visualizer !== e.vis)
            flag_error($sformatf("reset_visualizer %b, expected %b",
                                 res.reset_visualizer, e.vis));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else if (!hold_done && rx_count >= 200) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
        res.ready <= 1'b0;
      end else begin
        res.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (evt.valid && evt.ready) || (res.valid && res.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx == CFG_IDLE_LIMIT) lim_r = data[LIMIT_W-1:0];
    else if (idx == CFG_COOLDOWN) cool_s = data;
    else if (idx == CFG_FRESH) fresh_s = data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (req_q.size() != 0 || evt.valid || flags_q.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Random traffic: mostly stall scenarios (an input with no newer output, then a
  // run of check ticks), mixed with clock jumps, time-zero events and noise.
  task automatic gen_items(int n);
    int start;
    int nt;
    int lim_i;
    longint unsigned cool_ns;
    longint unsigned fresh_ns;
    longint unsigned back;
    start = req_q.size();
    lim_i = lim_r;
    cool_ns = 64'(cool_s) * NS_S;
    fresh_ns = 64'(fresh_s) * NS_S;
    while (req_q.size() - start < n) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: now_t += rand_ns(2 * NS_S);
        6, 7: now_t += TIME_W'(cool_ns) + rand_ns(2 * NS_S);
        8: now_t += rand_ns(2 * fresh_ns + NS_S);
        default: begin
          back = (now_t < 5 * NS_S) ? now_t : 5 * NS_S;
          now_t -= rand_ns(back);
        end
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          push_req(OP_INFER, now_t);
          now_t += rand_ns(NS_S / 10);
          push_req(OP_IMAGE, now_t);
          if ($urandom_range(0, 1) == 0) push_req(OP_DETECT, now_t + rand_ns(NS_S / 10));
        end
        4, 5: begin
          push_req(OP_IMAGE, now_t);
          now_t += rand_ns(NS_S / 10);
          push_req(OP_INFER, now_t);
        end
        6: push_req(OP_IMAGE, now_t);
        7: push_req(op_t'($urandom_range(0, 3)), '0);
        default: ;
      endcase
      if (lim_i <= 8) nt = $urandom_range(1, lim_i + 2);
      else if ($urandom_range(0, 15) == 0) nt = lim_i + 1;
      else nt = $urandom_range(1, 4);
      for (int k = 0; k < nt; k++) begin
        if ($urandom_range(0, 4) != 0) now_t += rand_ns(fresh_ns / (nt + 1));
        else now_t += rand_ns(2 * NS_S);
        if ($urandom_range(0, 9) == 0) begin
          if ($urandom_range(0, 2) == 0)
            push_req(op_t'($urandom_range(0, 3)), TIME_W'({$urandom, $urandom}));
          else
            push_req(op_t'($urandom_range(0, 3)), now_t);
        end
        push_req(OP_CHECK, now_t);
      end
    end
  endtask

  initial begin
    err_cnt = 0;
    rx_count = 0;
    hold_left = 0;
    hold_done = 1'b0;
    quiet_cycles = 0;
    now_t = sec(100);
    send_idle_pct = 6;
    recv_idle_pct = 78;
    lim_r = IDLE_LIMIT_RST;
    cool_s = COOLDOWN_RST;
    fresh_s = FRESH_RST;
    for (int s = 0; s < 2; s++) begin
      in_ns[s] = '0;
      out_ns[s] = '0;
      rst_ns[s] = '0;
      idle_cnt[s] = '0;
    end
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_IDLE_LIMIT;
    cfg_data = '0;
    evt.valid = 1'b0;
    evt.op = OP_IMAGE;
    evt.time_ns = '0;
    res.ready = 1'b0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed requests under the reset thresholds.
    push_req(OP_CHECK, '0);
    push_req(OP_IMAGE, '0);              // a time of zero reads as never
    push_req(OP_CHECK, 63'd5);
    push_req(OP_IMAGE, sec(1));
    push_req(OP_CHECK, sec(2));
    push_req(OP_CHECK, sec(3));
    push_req(OP_CHECK, sec(4));          // detector reaches the limit
    push_req(OP_CHECK, sec(5));          // inside the cooldown
    push_req(OP_CHECK, sec(20));         // input gone stale
    push_req(OP_INFER, sec(21));
    push_req(OP_IMAGE, sec(21));         // output as new as the input
    push_req(OP_CHECK, sec(22));
    push_req(OP_CHECK, sec(22));
    push_req(OP_CHECK, sec(22));         // visualizer reaches the limit
    push_req(OP_DETECT, sec(23));
    push_req(OP_IMAGE, sec(50));
    push_req(OP_CHECK, sec(40));         // time running backwards
    push_req(OP_IMAGE, MAX_T);
    push_req(OP_CHECK, MAX_T);
    push_req(OP_CHECK, '0);              // negative distance lies inside the cooldown
    push_req(OP_CHECK, MAX_T);
    push_req(OP_CHECK, 63'h5555_5555_5555_5555);
    push_req(OP_CHECK, 63'h2aaa_aaaa_aaaa_aaaa);

    for (int p = 0; p < 5; p++) begin
      wait_idle();
      if (p < 2) begin
        send_idle_pct = 6;
        recv_idle_pct = 78;
      end else if (p < 4) begin
        send_idle_pct = 78;
        recv_idle_pct = 6;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(CFG_UNUSED, CFG_DATA_W'($urandom_range(0, 4095)));
      case (p)
        0: begin
          write_reg(CFG_IDLE_LIMIT, 12'd1);
          write_reg(CFG_COOLDOWN, 12'd0);
          write_reg(CFG_FRESH, 12'd0);
        end
        1: begin
          write_reg(CFG_IDLE_LIMIT, 12'd3);
          write_reg(CFG_COOLDOWN, 12'd30);
          write_reg(CFG_FRESH, 12'd10);
        end
        2: begin
          write_reg(CFG_IDLE_LIMIT, 12'd255);
          write_reg(CFG_COOLDOWN, 12'd3600);
          write_reg(CFG_FRESH, 12'd3600);
        end
        3: begin
          // A limit of zero trips on the first counted idle check.
          write_reg(CFG_IDLE_LIMIT, 12'd0);
          write_reg(CFG_COOLDOWN, 12'd2);
          write_reg(CFG_FRESH, 12'd4095);
        end
        default: begin
          write_reg(CFG_IDLE_LIMIT, CFG_DATA_W'($urandom_range(2, 6)));
          write_reg(CFG_COOLDOWN, CFG_DATA_W'($urandom_range(0, 10)));
          write_reg(CFG_FRESH, CFG_DATA_W'($urandom_range(1, 20)));
        end
      endcase
      @(negedge clk);
      gen_items(75);
      // The sender pauses here until every outstanding result is back.
      wait_idle();
      gen_items(75);
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/pswd_pkg.sv
rtl/core/pswd_if.sv
rtl/core/pswd_stage.sv
rtl/core/pipeline_stall_watchdog.sv
sim/tb_top.sv
